@@ design/oale_pkg.sv @@
`default_nettype none

package oale_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 6;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int LIMIT_W  = 6;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_LOCATE = 2'd3
    } opcode_t;

    // What the datapath does with read data, which returns in the cycle after the read
    typedef enum logic [2:0] {
        RK_NONE,
        RK_UP,
        RK_DOWN,
        RK_CAP,
        RK_CMP
    } rd_kind_t;

    // Start value of the store pointer
    typedef enum logic [1:0] {
        PS_COUNT_M1,
        PS_POS_M1,
        PS_POS,
        PS_ZERO
    } ptr_src_t;

    typedef struct packed {
        logic     load_in;
        logic     ptr_load;
        ptr_src_t ptr_src;
        logic     ptr_inc;
        logic     ptr_dec;
        rd_kind_t rd_kind;
        logic     wr_item;
        logic     wr_zero;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     set_ok;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    ins_ok;
        logic    pos_ok;
        logic    list_empty;
        logic    append;
        logic    del_last;
        logic    ptr_at_pos_m1;
        logic    ptr_at_count_m1;
        logic    out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ design/oale_ram.sv @@
`default_nettype none

module oale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/oale_dp.sv @@
`default_nettype none

module oale_dp
    import oale_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic [LIMIT_W-1:0] limit,
    input  wire logic [OP_W-1:0]    in_opcode,
    input  wire logic [CNT_W-1:0]   in_position,
    input  wire logic [VAL_W-1:0]   in_value,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_ok,
    output logic [VAL_W-1:0]        out_result,
    output logic [CNT_W-1:0]        out_found,
    output logic [CNT_W-1:0]        out_length
);

    opcode_t          op_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [VAL_W-1:0] item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] ptr_reg;
    rd_kind_t         pend_kind_reg;
    logic [IDX_W-1:0] pend_addr_reg;
    logic             ok_reg;
    logic [VAL_W-1:0] res_reg;
    logic [CNT_W-1:0] found_reg;

    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [VAL_W-1:0] out_res_reg;
    logic [CNT_W-1:0] out_found_reg;
    logic [CNT_W-1:0] out_len_reg;

    logic [CNT_W-1:0] pos_m1;
    logic [CNT_W-1:0] count_m1;
    logic [CNT_W:0]   count_p1;
    logic [CNT_W-1:0] ptr_ext;
    logic             room;
    logic [IDX_W-1:0] ptr_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic [VAL_W-1:0] rdata;
    logic             pend_wr;
    logic             out_free;

    assign pos_m1   = pos_reg - CNT_W'(1);
    assign count_m1 = count_reg - CNT_W'(1);
    assign count_p1 = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign ptr_ext  = CNT_W'(ptr_reg);
    assign room     = (count_reg < limit) && (count_reg < CNT_W'(CAPACITY));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        sts.opcode          = op_reg;
        sts.ins_ok          = (pos_reg != '0) && ({1'b0, pos_reg} <= count_p1) && room;
        sts.pos_ok          = (pos_reg != '0) && (pos_reg <= count_reg);
        sts.list_empty      = (count_reg == '0);
        sts.append          = ({1'b0, pos_reg} == count_p1);
        sts.del_last        = (pos_reg == count_reg);
        sts.ptr_at_pos_m1   = (ptr_ext == pos_m1);
        sts.ptr_at_count_m1 = (ptr_ext == count_m1);
        sts.out_free        = out_free;
    end

    always_comb
    begin
        case (cmd.ptr_src)
            PS_COUNT_M1: ptr_next = count_m1[IDX_W-1:0];
            PS_POS_M1:   ptr_next = pos_m1[IDX_W-1:0];
            PS_POS:      ptr_next = pos_reg[IDX_W-1:0];
            PS_ZERO:     ptr_next = '0;
            default:     ptr_next = '0;
        endcase
    end

    // Shift writes land in the cycle after their read; the item and clear writes
    // never coincide with them.
    assign pend_wr = (pend_kind_reg == RK_UP) || (pend_kind_reg == RK_DOWN);

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (pend_kind_reg == RK_UP)
        begin
            we    = 1'b1;
            waddr = pend_addr_reg + IDX_W'(1);
            wdata = rdata;
        end
        else if (pend_kind_reg == RK_DOWN)
        begin
            we    = 1'b1;
            waddr = pend_addr_reg - IDX_W'(1);
            wdata = rdata;
        end
        else if (cmd.wr_item)
        begin
            we    = 1'b1;
            waddr = pos_m1[IDX_W-1:0];
            wdata = item_reg;
        end
        else if (cmd.wr_zero)
        begin
            we    = 1'b1;
            waddr = count_m1[IDX_W-1:0];
            wdata = '0;
        end
    end

    oale_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_kind_reg <= RK_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_kind_reg <= cmd.rd_kind;
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_m1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= ptr_reg;
        if (cmd.ptr_load)
        begin
            ptr_reg <= ptr_next;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_reg <= ptr_reg + IDX_W'(1);
        end
        else if (cmd.ptr_dec)
        begin
            ptr_reg <= ptr_reg - IDX_W'(1);
        end

        if (cmd.load_in)
        begin
            op_reg    <= opcode_t'(in_opcode);
            pos_reg   <= in_position;
            item_reg  <= in_value;
            ok_reg    <= 1'b0;
            res_reg   <= '0;
            found_reg <= '0;
        end
        else
        begin
            if (cmd.set_ok)
            begin
                ok_reg <= 1'b1;
            end
            if (pend_kind_reg == RK_CAP)
            begin
                res_reg <= rdata;
            end
            // keep the first match only
            if ((pend_kind_reg == RK_CMP) && (rdata == item_reg) && !ok_reg)
            begin
                ok_reg    <= 1'b1;
                found_reg <= CNT_W'(pend_addr_reg) + CNT_W'(1);
            end
        end

        if (cmd.load_out)
        begin
            out_ok_reg    <= ok_reg;
            out_res_reg   <= res_reg;
            out_found_reg <= found_reg;
            out_len_reg   <= count_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_ok     = out_ok_reg;
    assign out_result = out_res_reg;
    assign out_found  = out_found_reg;
    assign out_length = out_len_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_wr && (cmd.rd_kind != RK_NONE)) |-> (waddr != ptr_reg))
        else $error("shift write hits the address being read");

    a_out_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result loaded over an untaken result");

    a_shift_no_item_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pend_wr |-> !(cmd.wr_item || cmd.wr_zero))
        else $error("two writes to the store in one cycle");

endmodule

`default_nettype wire

@@ design/oale_ctrl.sv @@
`default_nettype none

module oale_ctrl
    import oale_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SHIFT_UP,
        ST_INS_DRAIN,
        ST_INS_WRITE,
        ST_DEL_READ,
        ST_SHIFT_DOWN,
        ST_DEL_DRAIN,
        ST_DEL_CLEAR,
        ST_GET_READ,
        ST_GET_DRAIN,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.ptr_src = PS_ZERO;
        cmd.rd_kind = RK_NONE;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.opcode)
                    OP_INSERT:
                    begin
                        if (!sts.ins_ok)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (sts.append)
                        begin
                            state_next = ST_INS_WRITE;
                        end
                        else
                        begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_src  = PS_COUNT_M1;
                            state_next   = ST_SHIFT_UP;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!sts.pos_ok)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_src  = PS_POS_M1;
                            state_next   = ST_DEL_READ;
                        end
                    end
                    OP_GET:
                    begin
                        if (!sts.pos_ok)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_src  = PS_POS_M1;
                            state_next   = ST_GET_READ;
                        end
                    end
                    OP_LOCATE:
                    begin
                        if (sts.list_empty)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.ptr_load = 1'b1;
                            cmd.ptr_src  = PS_ZERO;
                            state_next   = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SHIFT_UP:
            begin
                cmd.rd_kind = RK_UP;
                if (sts.ptr_at_pos_m1)
                begin
                    state_next = ST_INS_DRAIN;
                end
                else
                begin
                    cmd.ptr_dec = 1'b1;
                end
            end
            ST_INS_DRAIN:
            begin
                state_next = ST_INS_WRITE;
            end
            ST_INS_WRITE:
            begin
                cmd.wr_item = 1'b1;
                cmd.cnt_inc = 1'b1;
                cmd.set_ok  = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DEL_READ:
            begin
                cmd.rd_kind = RK_CAP;
                if (sts.del_last)
                begin
                    state_next = ST_DEL_CLEAR;
                end
                else
                begin
                    cmd.ptr_load = 1'b1;
                    cmd.ptr_src  = PS_POS;
                    state_next   = ST_SHIFT_DOWN;
                end
            end
            ST_SHIFT_DOWN:
            begin
                cmd.rd_kind = RK_DOWN;
                if (sts.ptr_at_count_m1)
                begin
                    state_next = ST_DEL_DRAIN;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_DEL_DRAIN:
            begin
                state_next = ST_DEL_CLEAR;
            end
            ST_DEL_CLEAR:
            begin
                cmd.wr_zero = 1'b1;
                cmd.cnt_dec = 1'b1;
                cmd.set_ok  = 1'b1;
                state_next  = ST_DONE;
            end
            ST_GET_READ:
            begin
                cmd.rd_kind = RK_CAP;
                cmd.set_ok  = 1'b1;
                state_next  = ST_GET_DRAIN;
            end
            ST_GET_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                cmd.rd_kind = RK_CMP;
                if (sts.ptr_at_count_m1)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end
            ST_SCAN_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_inc_only_valid_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> ((sts.opcode == OP_INSERT) && sts.ins_ok))
        else $error("count raised without a valid insert");

endmodule

`default_nettype wire

@@ design/ordered_array_list_engine.sv @@
`default_nettype none

// Channel       | Dir | Handshake                   | Payload
// --------------+-----+-----------------------------+------------------------------------
// s_axis        | in  | s_axis_tvalid/s_axis_tready | tuser: opcode; tdata: position, value
// m_axis        | out | m_axis_tvalid/m_axis_tready | tuser: ok; tdata: result, found, length
// APB config    | in  | psel/penable/pwrite/pready  | capacity_limit at byte address 0
//
// One operation at a time. The store is a single RAM with one write and one
// registered read port, so insert, delete and locate walk the list one entry
// per cycle.
// Reset clears the entry count and the result valid flag; the store needs no
// clearing pass, since entries past the count are never read.
// A result waits in the output register while the next transfer is taken; the
// engine stalls at the end of that operation only if the result is still there.

module ordered_array_list_engine
    import oale_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [5:0] position, [37:6] item_value, [39:38] zero
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] opcode

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // [31:0] result_value, [37:32] found_position,
                                            // [43:38] list_length, [47:44] zero
    output logic [0:0]       m_axis_tuser,  // [0] ok

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_CAPACITY_LIMIT = 1'b0;

    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_write;

    cmd_t               cmd;
    sts_t               sts;

    logic               out_ok;
    logic [VAL_W-1:0]   out_result;
    logic [CNT_W-1:0]   out_found;
    logic [CNT_W-1:0]   out_length;

    // Configuration: one register, written at the access phase of a transfer
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_CAPACITY_LIMIT))
        begin
            limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY_LIMIT) ? 32'(limit_reg) : '0;

    oale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    oale_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .limit       (limit_reg),
        .in_opcode   (s_axis_tuser),
        .in_position (s_axis_tdata[5:0]),
        .in_value    (s_axis_tdata[37:6]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_ok      (out_ok),
        .out_result  (out_result),
        .out_found   (out_found),
        .out_length  (out_length)
    );

    // Pack the result transfer, low field first
    assign m_axis_tdata = {4'b0000, out_length, out_found, out_result};
    assign m_axis_tuser = out_ok;

endmodule

`default_nettype wire

@@ dv/tb_ordered_array_list_engine.sv @@
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
    import oale_pkg::*;

    localparam logic [2:0] REG_CAPACITY_LIMIT = 3'd0;

    // One reply of the engine, fields in the order they appear on m_axis
    typedef struct packed {
        logic       ok;
        logic [31:0] value;
        logic [5:0] found;
        logic [5:0] length;
    } list_reply_t;

    // One row of the directed opening: the request, and for rows whose answer is
    // obvious (empty list, bad position, full list, the opening build) the reply typed in by hand
    typedef struct packed {
        opcode_t     op;
        logic [5:0]  pos;
        logic [31:0] val;
        logic        typed;
        list_reply_t reply;
    } probe_row_t;

    localparam logic        TYPED     = 1'b1;
    localparam logic        PREDICTED = 1'b0;
    localparam list_reply_t NO_REPLY  = '0;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;  // [5:0] position, [37:6] item_value, [39:38] zero
    logic [1:0]  s_axis_tuser  = '0;  // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [31:0] result_value, [37:32] found_position,
                                      // [43:38] list_length, [47:44] zero
    logic [0:0]  m_axis_tuser;        // [0] ok
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // Mirror of the list as the engine should hold it after every accepted transfer
    logic [31:0]         list_mirror [CAPACITY];
    int                  list_len  = 0;
    logic [LIMIT_W-1:0]  cap_limit = LIMIT_RESET;

    list_reply_t pending_replies [$];
    int          miscompares = 0;
    bit          steady_flow = 1'b0;
    list_reply_t seen_reply;
    list_reply_t want_reply;

    probe_row_t probe_rows [28] = '{
        // empty list: nothing to read, delete or find, bad insert positions
        '{OP_GET,    6'd1,  32'd0,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd0}},
        '{OP_DELETE, 6'd1,  32'd0,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd0}},
        '{OP_LOCATE, 6'd0,  32'd0,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd0}},
        '{OP_INSERT, 6'd0,  32'd5,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd0}},
        '{OP_INSERT, 6'd2,  32'd5,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd0}},
        // build 80000000, 0, 7fffffff, ffffffff: front, append and middle inserts
        '{OP_INSERT, 6'd1,  32'h7fffffff, TYPED, '{1'b1, 32'd0, 6'd0, 6'd1}},
        '{OP_INSERT, 6'd1,  32'h80000000, TYPED, '{1'b1, 32'd0, 6'd0, 6'd2}},
        '{OP_INSERT, 6'd3,  32'hffffffff, TYPED, '{1'b1, 32'd0, 6'd0, 6'd3}},
        '{OP_INSERT, 6'd2,  32'h00000000, TYPED, '{1'b1, 32'd0, 6'd0, 6'd4}},
        '{OP_GET,    6'd1,  32'd0,        TYPED, '{1'b1, 32'h80000000, 6'd0, 6'd4}},
        '{OP_GET,    6'd4,  32'd0,        TYPED, '{1'b1, 32'hffffffff, 6'd0, 6'd4}},
        '{OP_GET,    6'd5,  32'd0,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd4}},
        '{OP_GET,    6'd63, 32'd0,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd4}},
        '{OP_LOCATE, 6'd0,  32'h7fffffff, PREDICTED, NO_REPLY},
        '{OP_LOCATE, 6'd9,  32'd12345,    TYPED, '{1'b0, 32'd0, 6'd0, 6'd4}},
        '{OP_INSERT, 6'd6,  32'd1,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd4}},
        '{OP_DELETE, 6'd2,  32'd0,        PREDICTED, NO_REPLY},
        '{OP_DELETE, 6'd0,  32'd0,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd3}},
        '{OP_INSERT, 6'd4,  32'haaaaaaaa, PREDICTED, NO_REPLY},
        // duplicate value: locate must report the first copy
        '{OP_INSERT, 6'd2,  32'h55555555, PREDICTED, NO_REPLY},
        '{OP_INSERT, 6'd5,  32'h55555555, PREDICTED, NO_REPLY},
        '{OP_LOCATE, 6'd0,  32'h55555555, PREDICTED, NO_REPLY},
        // fill up to the reset limit of ten, then hit the full list
        '{OP_INSERT, 6'd1,  32'h00000001, PREDICTED, NO_REPLY},
        '{OP_INSERT, 6'd7,  32'hfffffffe, PREDICTED, NO_REPLY},
        '{OP_INSERT, 6'd9,  32'h40000000, PREDICTED, NO_REPLY},
        '{OP_INSERT, 6'd3,  32'hc0000000, PREDICTED, NO_REPLY},
        '{OP_INSERT, 6'd1,  32'd3,        TYPED, '{1'b0, 32'd0, 6'd0, 6'd10}},
        '{OP_DELETE, 6'd10, 32'd0,        PREDICTED, NO_REPLY}
    };

    ordered_array_list_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 clk = ~clk;

    // Apply one operation to the mirror and return the reply it must produce.
    // The usable limit is capped by the store size; entries above a lowered
    // limit stay in place and remain visible to delete, get and locate.
    function automatic list_reply_t apply_list_op(opcode_t op, logic [5:0] pos,
                                                  logic [31:0] val);
        list_reply_t r;
        int          n;
        int          p;
        int          lim;
        r   = '0;
        n   = list_len;
        p   = int'(pos);
        lim = (int'(cap_limit) > CAPACITY) ? CAPACITY : int'(cap_limit);
        case (op)
            OP_INSERT:
                if (p >= 1 && p <= n + 1 && n < lim)
                begin
                    for (int j = n; j >= p; j--)
                        list_mirror[j] = list_mirror[j-1];
                    list_mirror[p-1] = val;
                    n++;
                    r.ok = 1'b1;
                end
            OP_DELETE:
                if (p >= 1 && p <= n)
                begin
                    r.value = list_mirror[p-1];
                    for (int j = p; j < n; j++)
                        list_mirror[j-1] = list_mirror[j];
                    // the vacated top slot goes back to zero
                    list_mirror[n-1] = '0;
                    n--;
                    r.ok = 1'b1;
                end
            OP_GET:
                if (p >= 1 && p <= n)
                begin
                    r.value = list_mirror[p-1];
                    r.ok    = 1'b1;
                end
            default:
                for (int j = 0; j < n; j++)
                begin
                    if (list_mirror[j] == val)
                    begin
                        r.found = 6'(j + 1);
                        r.ok    = 1'b1;
                        break;
                    end
                end
        endcase
        list_len = n;
        r.length = 6'(n);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            miscompares++;
            if (miscompares <= 10)
                $display("%0t MISCOMPARE %s: expected %h, got %h", $realtime, name, want, got);
        end
    endfunction

    // Hold the request until it is taken, after a random gap unless the flow is
    // steady; log the reply at the edge that accepts the transfer.
    task automatic send_op(opcode_t op, logic [5:0] pos, logic [31:0] val,
                           logic typed, list_reply_t typed_reply);
        int          gap;
        list_reply_t predicted;
        gap = steady_flow ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, val, pos};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        predicted = apply_list_op(op, pos, val);
        pending_replies.push_back(typed ? typed_reply : predicted);
    endtask

    // Drop valid and wait until every logged reply has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Write the limit (junk in the unused upper bits), then read it back
    task automatic cfg_write(logic [LIMIT_W-1:0] lim);
        logic [31:0] wdata;
        wdata              = $urandom;
        wdata[LIMIT_W-1:0] = lim;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CAPACITY_LIMIT;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cap_limit = lim;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("capacity_limit readback", 32'(lim), 32'(prdata[LIMIT_W-1:0]));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One setting of the limit followed by random traffic. Insert share steers
    // the list toward full or toward empty; positions are mostly legal so the
    // shifting paths get exercised, with a slice drawn across the whole field.
    task automatic run_phase(logic [LIMIT_W-1:0] lim, int ins_pct, int items, bit steady);
        opcode_t     op;
        logic [5:0]  pos;
        logic [31:0] val;
        int          roll;
        drain_results();
        cfg_write(lim);
        steady_flow = steady;
        for (int k = 0; k < items; k++)
        begin
            // now and then stop feeding until the engine has answered everything
            if ($urandom_range(0, 59) == 0)
                drain_results();
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
                op = OP_INSERT;
            else
            begin
                case ($urandom_range(0, 2))
                    0:       op = OP_DELETE;
                    1:       op = OP_GET;
                    default: op = OP_LOCATE;
                endcase
            end
            if ($urandom_range(0, 6) == 0)
                pos = 6'($urandom_range(0, 63));
            else if (op == OP_INSERT)
                pos = 6'($urandom_range(1, list_len + 1));
            else
                pos = 6'($urandom_range(1, (list_len > 0) ? list_len : 1));
            val  = $urandom;
            roll = $urandom_range(0, 9);
            if (list_len > 0 && ((op == OP_LOCATE) ? (roll < 7) : (roll == 0)))
                val = list_mirror[$urandom_range(0, list_len - 1)];
            else if (roll == 9)
            begin
                case ($urandom_range(0, 3))
                    0:       val = 32'h00000000;
                    1:       val = 32'h7fffffff;
                    2:       val = 32'h80000000;
                    default: val = 32'hffffffff;
                endcase
            end
            send_op(op, pos, val, PREDICTED, NO_REPLY);
        end
    endtask

    // Result side: stall a random number of cycles before each transfer,
    // none at all while the flow is steady.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Compare every reply transfer against the oldest logged reply
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen_reply.ok     = m_axis_tuser[0];
            seen_reply.value  = m_axis_tdata[31:0];
            seen_reply.found  = m_axis_tdata[37:32];
            seen_reply.length = m_axis_tdata[43:38];
            if (pending_replies.size() == 0)
            begin
                miscompares++;
                if (miscompares <= 10)
                    $display("%0t MISCOMPARE reply with no request outstanding: %p",
                             $realtime, seen_reply);
            end
            else
            begin
                want_reply = pending_replies.pop_front();
                check_field("ok", 32'(want_reply.ok), 32'(seen_reply.ok));
                check_field("result_value", want_reply.value, seen_reply.value);
                check_field("found_position", 32'(want_reply.found), 32'(seen_reply.found));
                check_field("list_length", 32'(want_reply.length), 32'(seen_reply.length));
            end
        end
    end

    initial
    begin
        foreach (list_mirror[i])
            list_mirror[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset limit of ten
        foreach (probe_rows[i])
            send_op(probe_rows[i].op, probe_rows[i].pos, probe_rows[i].val,
                    probe_rows[i].typed, probe_rows[i].reply);

        // Fill to the full store, then lower the limit under the length, go down to
        // one and zero, past the store size, drain toward empty, and end at the limit of ten.
        run_phase(6'd32, 75, 70, 1'b0);
        run_phase(6'd32, 40, 60, 1'b1);
        run_phase(6'd5,  35, 50, 1'b0);
        run_phase(6'd1,  45, 40, 1'b0);
        run_phase(6'd0,  50, 30, 1'b1);
        run_phase(6'd63, 65, 80, 1'b0);
        run_phase(6'd20, 45, 70, 1'b0);
        run_phase(6'd32, 15, 90, 1'b0);
        run_phase(6'd10, 50, 40, 1'b1);

        // Wait out the last replies, then watch a full walk's worth of cycles
        // for anything spurious.
        drain_results();
        repeat (CAPACITY + 16) @(posedge clk);
        if (miscompares == 0)
            $display("ordered_array_list_engine: match");
        else
            $display("ordered_array_list_engine: mismatch");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("ordered_array_list_engine: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/oale_pkg.sv
design/oale_ram.sv
design/oale_dp.sv
design/oale_ctrl.sv
design/ordered_array_list_engine.sv
dv/tb_ordered_array_list_engine.sv
